// ----- design/h3fd_pkg.sv -----
// shared types, codes and helpers for the http/3 frame head decoder
package h3fd_pkg;

  localparam int DEF_MAX_PAIRS        = 16;
  localparam int DEF_MAX_BUFFER_BYTES = 65536;

  localparam int VAL_W   = 62;
  localparam int OUT_OFF_W = 17;
  localparam int OUT_CNT_W = 5;
  localparam int OUT_TDATA_W = 296;

  // record status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TRUNC = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_PAIRS = 3'd4;

  // decode modes
  localparam logic [2:0] MODE_GENERIC     = 3'd0;
  localparam logic [2:0] MODE_CANCEL_PUSH = 3'd1;
  localparam logic [2:0] MODE_GOAWAY      = 3'd2;
  localparam logic [2:0] MODE_MAX_PUSH_ID = 3'd3;
  localparam logic [2:0] MODE_SETTINGS    = 3'd4;

  // frame type codes
  localparam logic [VAL_W-1:0] FT_CANCEL_PUSH = 62'h03;
  localparam logic [VAL_W-1:0] FT_SETTINGS    = 62'h04;
  localparam logic [VAL_W-1:0] FT_GOAWAY      = 62'h07;
  localparam logic [VAL_W-1:0] FT_MAX_PUSH_ID = 62'h0d;

  // record kinds
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [7:0] {
    PH_TYPE     = 8'b0000_0001,
    PH_LENGTH   = 8'b0000_0010,
    PH_PAYLOAD  = 8'b0000_0100,
    PH_VALUE    = 8'b0000_1000,
    PH_PAIR_ID  = 8'b0001_0000,
    PH_PAIR_VAL = 8'b0010_0000,
    PH_DONE     = 8'b0100_0000,
    PH_STOP     = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic                 kind;
    logic [2:0]           status;
    logic [VAL_W-1:0]     frame_type;
    logic [VAL_W-1:0]     frame_length;
    logic [OUT_OFF_W-1:0] payload_offset;
    logic [OUT_OFF_W-1:0] consumed;
    logic [VAL_W-1:0]     single_value;
    logic [VAL_W-1:0]     setting_id;
    logic [OUT_CNT_W-1:0] pair_count;
    logic                 run_end;
  } rec_t;

  // frame type that a single-value or settings mode expects
  function automatic logic [VAL_W-1:0] mode_frame_type(input logic [2:0] mode);
    logic [VAL_W-1:0] t;
    case (mode)
      MODE_CANCEL_PUSH: t = FT_CANCEL_PUSH;
      MODE_GOAWAY:      t = FT_GOAWAY;
      MODE_MAX_PUSH_ID: t = FT_MAX_PUSH_ID;
      MODE_SETTINGS:    t = FT_SETTINGS;
      default:          t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- design/http3_frame_decoder_top.sv -----
// http/3 frame head decoder: type and length varints, settings pairs, status record
//
// usage
//   in_*  : one buffer byte per beat, in_tdata = data_byte, in_tlast = last byte
//           of the buffer
//   out_* : result records; out_tuser = record kind (0 settings pair, 1 final
//           status), out_tlast = last record caused by one input byte
//   cfg_* : decode mode write, always ready; write only while the block is idle,
//           the mode is taken at the first byte of each buffer
// latency: a byte is decoded in the cycle it is accepted and its records are
//   written into a four-entry output queue, so the first record shows on
//   out_* one cycle after the accepting edge
// throughput: one byte per cycle, set by the single-pass varint update; a byte
//   can cause two records (a pair finishing on the last byte), and in_tready
//   is high while the queue has room for two records
// reset: rst_n is synchronous; it clears the parse state, empties the queue
//   and sets the mode to generic
// stall: when out_tready stays low, records pile up in the queue and in_tready
//   drops once three are waiting; records are never lost or reordered
module http3_frame_decoder_top #(
  parameter int MAX_PAIRS        = h3fd_pkg::DEF_MAX_PAIRS,
  parameter int MAX_BUFFER_BYTES = h3fd_pkg::DEF_MAX_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result records
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [64:3] frame_type, [126:65] frame_length,
  // [143:127] payload_offset, [160:144] consumed, [222:161] single_value,
  // [284:223] setting_id, [289:285] pair_count, [295:290] zero
  output logic [h3fd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic        out_tuser,  // record_kind
  output logic        out_tlast,  // run_end
  // mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // decode_mode
);

  localparam int OFF_W = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int PC_W  = $clog2(MAX_PAIRS + 1);
  localparam int VW    = h3fd_pkg::VAL_W;
  localparam int OW    = h3fd_pkg::OUT_OFF_W;
  localparam int CW    = h3fd_pkg::OUT_CNT_W;

  // parse state
  logic [2:0]           mode_r;
  logic [2:0]           mode_latch_r, mode_latch_nxt;
  h3fd_pkg::phase_t     phase_r, phase_nxt;
  logic [VW-1:0]        accum_r, accum_nxt;
  logic [2:0]           left_r, left_nxt;
  logic [VW-1:0]        type_r, type_nxt;
  logic [VW-1:0]        length_r, length_nxt;
  logic [VW-1:0]        pend_id_r, pend_id_nxt;
  logic [VW-1:0]        value_r, value_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [OFF_W-1:0]     body_r, body_nxt;
  logic [VW:0]          end_r, end_nxt;     // body start plus length
  logic [PC_W-1:0]      pairs_r, pairs_nxt;
  logic [2:0]           err_r, err_nxt;

  // records of this beat
  h3fd_pkg::rec_t       pair_rec, fin_rec;
  logic                 pair_push, fin_push;

  // varint feed
  logic [VW-1:0]        fv_acc;
  logic [2:0]           fv_left;
  logic                 fv_done;

  logic                 in_fire;
  logic [7:0]           b;

  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign cfg_ready = 1'b1;

  // unused mode codes decode as generic
  function automatic logic cfg_mode_gen(input logic [2:0] m);
    return m > h3fd_pkg::MODE_SETTINGS;
  endfunction

  always_comb begin
    if (left_r == 3'd0) begin
      fv_acc = {{(VW-6){1'b0}}, b[5:0]};
      case (b[7:6])
        2'd0:    fv_left = 3'd0;
        2'd1:    fv_left = 3'd1;
        2'd2:    fv_left = 3'd3;
        default: fv_left = 3'd7;
      endcase
      fv_done = (b[7:6] == 2'd0);
    end else begin
      fv_acc  = {accum_r[VW-9:0], b};
      fv_left = left_r - 3'd1;
      fv_done = (left_r == 3'd1);
    end
  end

  always_comb begin
    logic [2:0]      st;
    logic            len_now;   // length varint completes on this beat
    logic            pay_trunc;
    logic [63:0]     off64, body64;
    logic [63:0]     pairs64;
    logic [OW-1:0]   cons17;
    logic [OFF_W-1:0] span;

    mode_latch_nxt = mode_latch_r;
    phase_nxt      = phase_r;
    accum_nxt      = accum_r;
    left_nxt       = left_r;
    type_nxt       = type_r;
    length_nxt     = length_r;
    pend_id_nxt    = pend_id_r;
    value_nxt      = value_r;
    off_nxt        = off_r;
    body_nxt       = body_r;
    end_nxt        = end_r;
    pairs_nxt      = pairs_r;
    err_nxt        = err_r;
    pair_push      = 1'b0;
    fin_push       = 1'b0;
    len_now        = 1'b0;
    st             = h3fd_pkg::ST_OK;
    pay_trunc      = 1'b0;
    cons17         = '0;
    span           = '0;

    if (in_fire && (off_r < OFF_W'(MAX_BUFFER_BYTES))) begin
      if (off_r == '0) begin
        mode_latch_nxt = (cfg_mode_gen(mode_r)) ? h3fd_pkg::MODE_GENERIC : mode_r;
      end
      off_nxt = off_r + OFF_W'(1);
      span    = off_nxt - body_r;
      case (phase_r)
        h3fd_pkg::PH_TYPE: begin
          accum_nxt = fv_acc;
          left_nxt  = fv_left;
          if (fv_done) begin
            type_nxt  = fv_acc;
            phase_nxt = h3fd_pkg::PH_LENGTH;
          end
        end
        h3fd_pkg::PH_LENGTH: begin
          accum_nxt = fv_acc;
          left_nxt  = fv_left;
          if (fv_done) begin
            len_now    = 1'b1;
            length_nxt = fv_acc;
            body_nxt   = off_nxt;
            end_nxt    = (VW+1)'(off_nxt) + {1'b0, fv_acc};
            if (mode_latch_r == h3fd_pkg::MODE_GENERIC) begin
              phase_nxt = (fv_acc == '0) ? h3fd_pkg::PH_DONE : h3fd_pkg::PH_PAYLOAD;
            end else if (type_r != h3fd_pkg::mode_frame_type(mode_latch_r)) begin
              err_nxt   = h3fd_pkg::ST_TYPE;
              phase_nxt = h3fd_pkg::PH_STOP;
            end else if (mode_latch_r == h3fd_pkg::MODE_SETTINGS) begin
              phase_nxt = (fv_acc == '0) ? h3fd_pkg::PH_DONE : h3fd_pkg::PH_PAIR_ID;
            end else begin
              phase_nxt = h3fd_pkg::PH_VALUE;
            end
          end
        end
        h3fd_pkg::PH_PAYLOAD: begin
          if (VW'(span) >= length_r) phase_nxt = h3fd_pkg::PH_DONE;
        end
        h3fd_pkg::PH_VALUE: begin
          accum_nxt = fv_acc;
          left_nxt  = fv_left;
          if (fv_done) begin
            value_nxt = fv_acc;
            if (VW'(span) != length_r) begin
              err_nxt   = h3fd_pkg::ST_LEN;
              phase_nxt = h3fd_pkg::PH_STOP;
            end else begin
              phase_nxt = h3fd_pkg::PH_DONE;
            end
          end
        end
        h3fd_pkg::PH_PAIR_ID: begin
          if (left_r == 3'd0 && pairs_r >= PC_W'(MAX_PAIRS)) begin
            err_nxt   = h3fd_pkg::ST_PAIRS;
            phase_nxt = h3fd_pkg::PH_STOP;
          end else begin
            accum_nxt = fv_acc;
            left_nxt  = fv_left;
            if ((VW+1)'(off_nxt) >= end_r) begin
              err_nxt   = h3fd_pkg::ST_LEN;
              phase_nxt = h3fd_pkg::PH_STOP;
            end else if (fv_done) begin
              pend_id_nxt = fv_acc;
              phase_nxt   = h3fd_pkg::PH_PAIR_VAL;
            end
            if (fv_done) pend_id_nxt = fv_acc;
          end
        end
        h3fd_pkg::PH_PAIR_VAL: begin
          accum_nxt = fv_acc;
          left_nxt  = fv_left;
          if (fv_done) begin
            pairs_nxt = pairs_r + PC_W'(1);
            pair_push = 1'b1;
            phase_nxt = ((VW+1)'(off_nxt) >= end_r) ? h3fd_pkg::PH_DONE
                                                    : h3fd_pkg::PH_PAIR_ID;
          end else if ((VW+1)'(off_nxt) >= end_r) begin
            err_nxt   = h3fd_pkg::ST_LEN;
            phase_nxt = h3fd_pkg::PH_STOP;
          end
        end
        default: ;
      endcase
    end

    off64   = 64'(off_nxt);
    body64  = 64'(body_nxt);
    pairs64 = 64'(pairs_nxt);

    pair_rec.kind           = h3fd_pkg::KIND_PAIR;
    pair_rec.status         = h3fd_pkg::ST_OK;
    pair_rec.frame_type     = type_nxt;
    pair_rec.frame_length   = length_nxt;
    pair_rec.payload_offset = body64[OW-1:0];
    pair_rec.consumed       = off64[OW-1:0];
    pair_rec.single_value   = fv_acc;
    pair_rec.setting_id     = pend_id_r;
    pair_rec.pair_count     = pairs64[CW-1:0];
    pair_rec.run_end        = !in_tlast;

    // final status record
    st = err_nxt;
    if (st == h3fd_pkg::ST_OK && phase_nxt != h3fd_pkg::PH_DONE) st = h3fd_pkg::ST_TRUNC;
    // settings payload that reaches past the bytes seen so far
    pay_trunc = len_now ? (length_nxt != '0) : (end_r > (VW+1)'(off_nxt));
    if (mode_latch_nxt == h3fd_pkg::MODE_SETTINGS && body_nxt != '0 &&
        type_nxt == h3fd_pkg::FT_SETTINGS && pay_trunc) begin
      st = h3fd_pkg::ST_TRUNC;
    end
    cons17 = body64[OW-1:0] + length_nxt[OW-1:0];

    fin_rec.kind           = h3fd_pkg::KIND_FINAL;
    fin_rec.status         = st;
    fin_rec.frame_type     = type_nxt;
    fin_rec.frame_length   = length_nxt;
    fin_rec.payload_offset = body64[OW-1:0];
    fin_rec.consumed       = (st == h3fd_pkg::ST_OK) ? cons17 : '0;
    fin_rec.single_value   = (st == h3fd_pkg::ST_OK &&
                              mode_latch_nxt != h3fd_pkg::MODE_GENERIC &&
                              mode_latch_nxt != h3fd_pkg::MODE_SETTINGS) ? value_nxt : '0;
    fin_rec.setting_id     = '0;
    fin_rec.pair_count     = (mode_latch_nxt == h3fd_pkg::MODE_SETTINGS) ?
                             pairs64[CW-1:0] : '0;
    fin_rec.run_end        = 1'b1;

    if (in_fire && in_tlast) begin
      fin_push       = 1'b1;
      // back to the reset state for the next buffer
      mode_latch_nxt = h3fd_pkg::MODE_GENERIC;
      phase_nxt      = h3fd_pkg::PH_TYPE;
      accum_nxt      = '0;
      left_nxt       = '0;
      type_nxt       = '0;
      length_nxt     = '0;
      pend_id_nxt    = '0;
      value_nxt      = '0;
      off_nxt        = '0;
      body_nxt       = '0;
      end_nxt        = '0;
      pairs_nxt      = '0;
      err_nxt        = h3fd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= h3fd_pkg::MODE_GENERIC;
      mode_latch_r <= h3fd_pkg::MODE_GENERIC;
      phase_r      <= h3fd_pkg::PH_TYPE;
      accum_r      <= '0;
      left_r       <= '0;
      type_r       <= '0;
      length_r     <= '0;
      pend_id_r    <= '0;
      value_r      <= '0;
      off_r        <= '0;
      body_r       <= '0;
      end_r        <= '0;
      pairs_r      <= '0;
      err_r        <= h3fd_pkg::ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) mode_r <= cfg_data;
      mode_latch_r <= mode_latch_nxt;
      phase_r      <= phase_nxt;
      accum_r      <= accum_nxt;
      left_r       <= left_nxt;
      type_r       <= type_nxt;
      length_r     <= length_nxt;
      pend_id_r    <= pend_id_nxt;
      value_r      <= value_nxt;
      off_r        <= off_nxt;
      body_r       <= body_nxt;
      end_r        <= end_nxt;
      pairs_r      <= pairs_nxt;
      err_r        <= err_nxt;
    end
  end

  // output record queue, four entries
  h3fd_pkg::rec_t q_mem [4];
  logic [1:0]     wr_ptr_r, rd_ptr_r;
  logic [2:0]     q_cnt_r;
  logic           q_pop;
  logic [1:0]     n_push;
  h3fd_pkg::rec_t head;

  assign q_pop      = out_tvalid && out_tready;
  assign n_push     = {1'b0, pair_push} + {1'b0, fin_push};
  assign in_tready  = (q_cnt_r < 3'd3);
  assign out_tvalid = (q_cnt_r != 3'd0);
  assign head       = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (pair_push) q_mem[wr_ptr_r] <= pair_rec;
    if (fin_push)  q_mem[pair_push ? wr_ptr_r + 2'd1 : wr_ptr_r] <= fin_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      q_cnt_r  <= q_cnt_r + {1'b0, n_push} - {2'b00, q_pop};
    end
  end

  assign out_tdata = {6'd0, head.pair_count, head.setting_id, head.single_value,
                      head.consumed, head.payload_offset, head.frame_length,
                      head.frame_type, head.status};
  assign out_tuser = head.kind;
  assign out_tlast = head.run_end;

endmodule

// ----- design/h3fd_checker.sv -----
// port-level checks on the decoder result channel, bound to the top level
module h3fd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [h3fd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // a stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled record changed");

  // a final status record always closes the records of its beat
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == h3fd_pkg::KIND_FINAL |-> out_tlast)
    else $error("final record without run end");

  // a settings pair record is ok and counts at least one pair
  a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == h3fd_pkg::KIND_PAIR |->
      out_tdata[2:0] == h3fd_pkg::ST_OK && out_tdata[289:285] != 5'd0)
    else $error("bad settings pair record");

  // a failed frame reports nothing consumed and no value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == h3fd_pkg::KIND_FINAL &&
    out_tdata[2:0] != h3fd_pkg::ST_OK |->
      out_tdata[160:144] == 17'd0 && out_tdata[222:161] == 62'd0)
    else $error("failed frame carries consumed or value");

endmodule

bind http3_frame_decoder_top h3fd_checker u_h3fd_checker (.*);

// ----- tb/sv/http3_frame_decoder_top_test.sv -----
// self-checking testbench for the http/3 frame head decoder with its own frame predictor
`timescale 1ns / 1ps

module http3_frame_decoder_top_test;
  import h3fd_pkg::*;

  // limits of the decoder as built with its default parameters
  localparam int BUF_MAX       = DEF_MAX_BUFFER_BYTES;
  localparam int PAIR_MAX      = DEF_MAX_PAIRS;
  // a mode code with no meaning of its own, decodes as generic
  localparam logic [2:0] MODE_SPARE = 3'd7;
  // quiet cycles before a mode write and before the final verdict
  localparam int DRAIN_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 10;
  // a full run stays well under this limit even at the heaviest idling
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int BYTES_PER_PASS = 150;

  // one result record, split into its fields
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [61:0] ftype;
    logic [61:0] flen;
    logic [16:0] poff;
    logic [16:0] cons;
    logic [61:0] sval;
    logic [61:0] sid;
    logic [4:0]  pcnt;
    logic        run_end;
  } frame_rec_t;

  // one row of the directed stimulus: a mode write or a buffer byte
  typedef struct {
    bit         wr;     // row writes the mode register
    logic [2:0] mode;
    logic [7:0] b;
    bit         lst;
    bit         typed;  // final status of this buffer is typed in below
    logic [2:0] st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_data = 3'd0;

  http3_frame_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame predictor: mirrors the decoder state, one accepted byte at a time
  // ---------------------------------------------------------------------------

  // frame type each non-generic mode insists on, indexed by mode
  logic [61:0] type_for_mode [5] = '{62'd0, FT_CANCEL_PUSH, FT_GOAWAY,
                                     FT_MAX_PUSH_ID, FT_SETTINGS};

  logic [2:0]  mode_reg = MODE_GENERIC;  // last written decode mode
  logic [2:0]  cur_mode;                 // mode taken at the first byte of the buffer
  phase_t      cur_phase;
  logic [61:0] acc;                      // varint being assembled
  int          acc_left;                 // varint bytes still to come
  logic [61:0] f_type, f_len, f_id, f_val;
  int unsigned f_off, f_body, f_pairs;
  logic [2:0]  f_err;

  frame_rec_t  due_records [$];          // records the decoder still owes us
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 74;
  int          cycles = 0;

  logic [7:0]  frame_bytes [$];          // buffer under construction

  function automatic void clear_frame();
    cur_mode  = MODE_GENERIC;
    cur_phase = PH_TYPE;
    acc       = '0;
    acc_left  = 0;
    f_type    = '0;
    f_len     = '0;
    f_id      = '0;
    f_val     = '0;
    f_off     = 0;
    f_body    = 0;
    f_pairs   = 0;
    f_err     = ST_OK;
  endfunction

  // shift one byte into the varint; true once the varint is whole
  function automatic bit take_varint(input logic [7:0] b);
    if (acc_left == 0) begin
      acc      = {56'd0, b[5:0]};
      acc_left = (1 << b[7:6]) - 1;
    end else begin
      acc      = {acc[53:0], b};
      acc_left = acc_left - 1;
    end
    return acc_left == 0;
  endfunction

  function automatic void halt(input logic [2:0] code);
    f_err     = code;
    cur_phase = PH_STOP;
  endfunction

  function automatic frame_rec_t make_rec(input logic kind, input logic [2:0] st,
                                          input logic [16:0] cons, input logic [61:0] val,
                                          input logic [61:0] id, input logic [4:0] cnt);
    frame_rec_t r;
    r.kind    = kind;
    r.status  = st;
    r.ftype   = f_type;
    r.flen    = f_len;
    r.poff    = 17'(f_body);
    r.cons    = cons;
    r.sval    = val;
    r.sid     = id;
    r.pcnt    = cnt;
    r.run_end = 1'b0;
    return r;
  endfunction

  // work out the records one accepted byte causes and queue them
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    frame_rec_t  recs [$];
    logic [63:0] pay_end;
    logic [2:0]  st;
    logic [16:0] cons;
    logic [61:0] val;
    logic [4:0]  cnt;
    pay_end = 64'(f_body) + 64'(f_len);
    // bytes past the buffer limit are neither parsed nor counted
    if (f_off < BUF_MAX) begin
      if (f_off == 0) cur_mode = (mode_reg > MODE_SETTINGS) ? MODE_GENERIC : mode_reg;
      f_off++;
      case (cur_phase)
        PH_TYPE: begin
          if (take_varint(b)) begin
            f_type    = acc;
            cur_phase = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (take_varint(b)) begin
            f_len  = acc;
            f_body = f_off;
            if (cur_mode == MODE_GENERIC) begin
              cur_phase = (f_len == 0) ? PH_DONE : PH_PAYLOAD;
            end else if (f_type != type_for_mode[cur_mode]) begin
              halt(ST_TYPE);
            end else if (cur_mode == MODE_SETTINGS) begin
              cur_phase = (f_len == 0) ? PH_DONE : PH_PAIR_ID;
            end else begin
              cur_phase = PH_VALUE;
            end
          end
        end
        PH_PAYLOAD: begin
          if (64'(f_off - f_body) >= 64'(f_len)) cur_phase = PH_DONE;
        end
        PH_VALUE: begin
          // the single value must end exactly where the payload ends
          if (take_varint(b)) begin
            f_val = acc;
            if (64'(f_off - f_body) != 64'(f_len)) halt(ST_LEN);
            else cur_phase = PH_DONE;
          end
        end
        PH_PAIR_ID: begin
          if (acc_left == 0 && f_pairs >= PAIR_MAX) begin
            halt(ST_PAIRS);
          end else if (take_varint(b)) begin
            f_id = acc;
            if (64'(f_off) >= pay_end) halt(ST_LEN);
            else cur_phase = PH_PAIR_VAL;
          end else if (64'(f_off) >= pay_end) begin
            halt(ST_LEN);
          end
        end
        PH_PAIR_VAL: begin
          if (take_varint(b)) begin
            f_pairs++;
            recs.push_back(make_rec(KIND_PAIR, ST_OK, 17'(f_off), acc, f_id, 5'(f_pairs)));
            cur_phase = (64'(f_off) >= pay_end) ? PH_DONE : PH_PAIR_ID;
          end else if (64'(f_off) >= pay_end) begin
            halt(ST_LEN);
          end
        end
        default: ;
      endcase
    end

    // closing byte: one status record, then back to the reset state
    if (lst) begin
      st   = f_err;
      cons = '0;
      val  = '0;
      cnt  = '0;
      if (st == ST_OK && cur_phase != PH_DONE) st = ST_TRUNC;
      if (cur_mode == MODE_SETTINGS) begin
        cnt = 5'(f_pairs);
        // a settings payload that runs past the buffer overrides earlier errors
        if (f_body != 0 && f_type == FT_SETTINGS &&
            64'(f_body) + 64'(f_len) > 64'(f_off)) st = ST_TRUNC;
      end
      if (st == ST_OK) begin
        cons = 17'(64'(f_body) + 64'(f_len));
        if (cur_mode != MODE_GENERIC && cur_mode != MODE_SETTINGS) val = f_val;
      end
      recs.push_back(make_rec(KIND_FINAL, st, cons, val, '0, cnt));
      clear_frame();
    end

    if (recs.size() > 0) recs[recs.size() - 1].run_end = 1'b1;
    foreach (recs[i]) due_records.push_back(recs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // drivers: one byte beat, one mode write, one whole buffer
  // ---------------------------------------------------------------------------

  // offer a byte with random idle cycles in front, predict once it is taken
  task automatic push_byte(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, lst);
    bytes_sent++;
  endtask

  // mode writes only go in once every owed record is out and the block is quiet
  task automatic program_mode(input logic [2:0] m);
    in_tvalid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_reg = m;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // random buffer construction
  // ---------------------------------------------------------------------------

  // varint width in bytes, short ones most of the time
  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 1;
    if (r < 75) return 2;
    if (r < 90) return 4;
    return 8;
  endfunction

  // value that fits a varint of sz bytes, with zero and all ones favored
  function automatic logic [61:0] pick_value(input int sz);
    logic [61:0] mask;
    int          r;
    mask = (62'd1 << (8 * sz - 2)) - 62'd1;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return mask;
    return 62'({$urandom, $urandom}) & mask;
  endfunction

  // widen the encoding until the value fits
  function automatic int fit_size(input logic [61:0] v, input int sz);
    int s;
    s = sz;
    while (s < 8 && (v >> (8 * s - 2)) != 0) s = s * 2;
    return s;
  endfunction

  // big-endian varint with the size code in the top two bits
  task automatic put_varint(ref logic [7:0] dst [$], input logic [61:0] v, input int sz);
    logic [63:0] w;
    logic [1:0]  code;
    code = (sz == 1) ? 2'd0 : (sz == 2) ? 2'd1 : (sz == 4) ? 2'd2 : 2'd3;
    w = {2'b00, v} | ({62'd0, code} << (8 * sz - 2));
    for (int i = sz - 1; i >= 0; i--) dst.push_back(w[8 * i +: 8]);
  endtask

  // mostly well-formed frames for the active mode; some noise, some broken
  task automatic build_frame(input logic [2:0] m);
    logic [7:0]  body [$];
    logic [61:0] ftype, flen, v;
    logic [2:0]  eff;
    int          npairs, keep, sz;
    frame_bytes.delete();
    eff = (m > MODE_SETTINGS) ? MODE_GENERIC : m;
    // plain noise
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
      return;
    end

    if (eff != MODE_GENERIC && $urandom_range(99) < 85) begin
      ftype = type_for_mode[eff];
    end else begin
      sz    = pick_size();
      ftype = ($urandom_range(1) == 1) ? 62'($urandom_range(15)) : pick_value(sz);
    end

    if (eff == MODE_GENERIC) begin
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
    end else if (eff == MODE_SETTINGS) begin
      // now and then a pair count from just under the pair limit to past it
      npairs = ($urandom_range(99) < 20) ? $urandom_range(PAIR_MAX - 1, PAIR_MAX + 2)
                                         : $urandom_range(0, 3);
      repeat (npairs) begin
        sz = pick_size();
        put_varint(body, pick_value(sz), sz);
        sz = pick_size();
        put_varint(body, pick_value(sz), sz);
      end
    end else begin
      sz = pick_size();
      v  = pick_value(sz);
      put_varint(body, v, sz);
    end

    flen = 62'(body.size());
    // off-by-one and huge lengths
    case ($urandom_range(19))
      0, 1: flen = flen + 62'd1;
      2, 3: if (flen != 0) flen = flen - 62'd1;
      4:    flen = '1;
      default: ;
    endcase

    put_varint(frame_bytes, ftype, fit_size(ftype, pick_size()));
    put_varint(frame_bytes, flen, fit_size(flen, pick_size()));
    foreach (body[i]) frame_bytes.push_back(body[i]);

    // cut short, or padded with bytes the decoder must ignore
    if ($urandom_range(99) < 10) begin
      keep = $urandom_range(1, frame_bytes.size());
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end else if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(9);
    return (r > 7) ? MODE_SETTINGS : 3'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows: each short buffer closes with a status that is plain to see
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [35] = '{
    // right after reset, generic: empty type and length
    '{1, MODE_GENERIC,     8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h00, 1, 1, ST_OK},
    // two-byte type at its top value, one payload byte
    '{0, MODE_GENERIC,     8'h7f, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'hff, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h01, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'haa, 1, 1, ST_OK},
    // cancel push: good frame, then the wrong type
    '{1, MODE_CANCEL_PUSH, 8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h03, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h01, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h05, 1, 1, ST_OK},
    '{0, MODE_GENERIC,     8'h07, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h01, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h05, 1, 1, ST_TYPE},
    // goaway: value shorter than length, trailing byte ignored
    '{1, MODE_GOAWAY,      8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h07, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h02, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h05, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h00, 1, 1, ST_LEN},
    // settings: second pair starts on the payload end
    '{1, MODE_SETTINGS,    8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h04, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h03, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h01, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h02, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h06, 1, 1, ST_LEN},
    // settings: payload longer than the buffer, the pair record still stands
    '{0, MODE_GENERIC,     8'h04, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h08, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h01, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h02, 1, 1, ST_TRUNC},
    // unused mode code, buffer ends inside an eight-byte varint
    '{1, MODE_SPARE,       8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'hff, 1, 1, ST_TRUNC},
    // max push id with a one-byte value at its top
    '{1, MODE_MAX_PUSH_ID, 8'h00, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h0d, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h01, 0, 0, ST_OK},
    '{0, MODE_GENERIC,     8'h3f, 1, 1, ST_OK}
  };

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the field by field compare
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : rx_side
    frame_rec_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[2:0];
      got.ftype   = out_tdata[64:3];
      got.flen    = out_tdata[126:65];
      got.poff    = out_tdata[143:127];
      got.cons    = out_tdata[160:144];
      got.sval    = out_tdata[222:161];
      got.sid     = out_tdata[284:223];
      got.pcnt    = out_tdata[289:285];
      got.kind    = out_tuser;
      got.run_end = out_tlast;
      if (due_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: record beat with none expected", $time);
      end else begin
        want = due_records.pop_front();
        check_field("record_kind",    64'(want.kind),    64'(got.kind));
        check_field("status",         64'(want.status),  64'(got.status));
        check_field("frame_type",     64'(want.ftype),   64'(got.ftype));
        check_field("frame_length",   64'(want.flen),    64'(got.flen));
        check_field("payload_offset", 64'(want.poff),    64'(got.poff));
        check_field("consumed",       64'(want.cons),    64'(got.cons));
        check_field("single_value",   64'(want.sval),    64'(got.sval));
        check_field("setting_id",     64'(want.sid),     64'(got.sid));
        check_field("pair_count",     64'(want.pcnt),    64'(got.pcnt));
        check_field("run_end",        64'(want.run_end), 64'(got.run_end));
        check_field("tdata pad",      64'd0,             64'(out_tdata[295:290]));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on total run length
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_frame();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, sender idles lightly and receiver heavily
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        program_mode(dir_rows[i].mode);
      end else begin
        push_byte(dir_rows[i].b, dir_rows[i].lst);
        if (dir_rows[i].typed) due_records[due_records.size() - 1].status = dir_rows[i].st;
      end
    end

    // random buffers in three idling regimes, mode rewritten before each group of buffers
    bytes_sent = 0;
    for (int pass_i = 0; pass_i < 3; pass_i++) begin
      case (pass_i)
        0: begin send_idle_pct = 30; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (bytes_sent < BYTES_PER_PASS * (pass_i + 1)) begin
        program_mode(pick_mode());
        repeat ($urandom_range(2, 5)) begin
          build_frame(mode_reg);
          send_frame();
        end
      end
    end

    // drain and let the block settle before the verdict
    in_tvalid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_records.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- http3_frame_decoder_top.f -----
design/h3fd_pkg.sv
design/http3_frame_decoder_top.sv
design/h3fd_checker.sv
tb/sv/http3_frame_decoder_top_test.sv
